@@ design/dense_layer_forward_backward_unit_macros.svh @@
// ----------------------------------------------------------------------------
// Dense layer unit assertion macros
// Concurrent assertion wrappers, empty when synthesising.
// ----------------------------------------------------------------------------
`ifndef DENSE_LAYER_FORWARD_BACKWARD_UNIT_MACROS_SVH
`define DENSE_LAYER_FORWARD_BACKWARD_UNIT_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define DLFB_ASSERT_IMP(lbl, clk, rst, a, b) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("dlfb assertion failed");
// next-cycle implication
`define DLFB_ASSERT_NXT(lbl, clk, rst, a, b) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("dlfb assertion failed");
`else
`define DLFB_ASSERT_IMP(lbl, clk, rst, a, b)
`define DLFB_ASSERT_NXT(lbl, clk, rst, a, b)
`endif
`endif

@@ design/dlfb_pkg.sv @@
// ----------------------------------------------------------------------------
// dlfb_pkg
// Types, constants and saturation helpers of the dense layer unit.
// ----------------------------------------------------------------------------
`default_nettype none

package dlfb_pkg;

  localparam int NUM_INPUTS  = 64;
  localparam int NUM_NEURONS = 16;
  localparam int FRAC_BITS   = 12;

  localparam int W_DEPTH = NUM_INPUTS * NUM_NEURONS;
  localparam int NI_W    = (NUM_INPUTS > 1) ? $clog2(NUM_INPUTS) : 1;
  localparam int NN_W    = (NUM_NEURONS > 1) ? $clog2(NUM_NEURONS) : 1;
  localparam int WA_W    = (W_DEPTH > 1) ? $clog2(W_DEPTH) : 1;
  localparam int CNT_W   = $clog2(W_DEPTH + 1);

  // command codes
  localparam logic [3:0] FN_WSET = 4'd0;
  localparam logic [3:0] FN_WADD = 4'd1;
  localparam logic [3:0] FN_BSET = 4'd2;
  localparam logic [3:0] FN_BADD = 4'd3;
  localparam logic [3:0] FN_FWD  = 4'd4;
  localparam logic [3:0] FN_BWD  = 4'd5;
  localparam logic [3:0] FN_RDW  = 4'd6;
  localparam logic [3:0] FN_RDB  = 4'd7;
  localparam logic [3:0] FN_CLR  = 4'd8;

  // result kinds
  localparam logic [1:0] KIND_OUT  = 2'd0;
  localparam logic [1:0] KIND_DX   = 2'd1;
  localparam logic [1:0] KIND_DW   = 2'd2;
  localparam logic [1:0] KIND_DB   = 2'd3;

  typedef enum logic [3:0] {
    OP_WSET, OP_WADD, OP_BSET, OP_BADD, OP_FACC, OP_FOUT,
    OP_BACC, OP_BOUT, OP_RDW, OP_RDB, OP_CLR, OP_INIT
  } op_e;

  typedef struct packed {
    logic [3:0]         func;
    logic [5:0]         row;
    logic [3:0]         col;
    logic signed [15:0] value;
    logic               last;
  } cmd_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic [9:0]         index;
    logic signed [31:0] result_value;
    logic               end_of_run;
  } result_t;

  // one sequencer step
  typedef struct packed {
    logic             vld;
    op_e              op;
    logic [CNT_W-1:0] cnt;
  } step_t;

  function automatic logic [WA_W-1:0] waddr(input logic [NI_W-1:0] i,
                                            input logic [NN_W-1:0] j);
    return WA_W'(32'(i) * NUM_NEURONS + 32'(j));
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [16:0] x);
    if (x[16] != x[15]) return x[16] ? 16'sh8000 : 16'sh7fff;
    return x[15:0];
  endfunction

  function automatic logic signed [39:0] sat40(input logic signed [40:0] x);
    if (x[40] != x[39]) return x[40] ? 40'sh80_0000_0000 : 40'sh7f_ffff_ffff;
    return x[39:0];
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [40:0] x);
    if (x > 41'sh0_7fff_ffff) return 32'sh7fff_ffff;
    if (x < -41'sh0_8000_0000) return 32'sh8000_0000;
    return x[31:0];
  endfunction

endpackage

`default_nettype wire

@@ design/dlfb_ram.sv @@
// ----------------------------------------------------------------------------
// dlfb_ram
// Simple dual port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module dlfb_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port, addresses past the depth are dropped
  always_ff @(posedge clk) begin
    if (we && (32'(waddr) < DEPTH)) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ design/dlfb_seq.sv @@
// ----------------------------------------------------------------------------
// dlfb_seq
// Command sequencer: decodes a command into runs of memory steps.
// ----------------------------------------------------------------------------
`default_nettype none
`include "dense_layer_forward_backward_unit_macros.svh"

module dlfb_seq
  import dlfb_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic start,
  input  wire cmd_t cmd,
  output logic      busy,
  output cmd_t      itm,
  output step_t     step
);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_RUN   = 3'b010,
    ST_DRAIN = 3'b100
  } state_e;

  state_e           state;
  op_e              op;
  logic [CNT_W-1:0] cnt;
  logic [CNT_W-1:0] nsteps;
  logic             pend;
  op_e              pend_op;
  logic [CNT_W-1:0] pend_n;
  logic             dcnt;

  op_e              dec_op;
  logic [CNT_W-1:0] dec_n;
  logic             dec_go;
  logic             dec_pend;
  op_e              dec_pend_op;
  logic [CNT_W-1:0] dec_pend_n;

  // decode the incoming command
  always_comb begin
    dec_op      = OP_WSET;
    dec_n       = CNT_W'(1);
    dec_go      = 1'b1;
    dec_pend    = 1'b0;
    dec_pend_op = OP_FOUT;
    dec_pend_n  = CNT_W'(NUM_NEURONS);
    unique case (cmd.func)
      FN_WSET: dec_op = OP_WSET;
      FN_WADD: dec_op = OP_WADD;
      FN_BSET: dec_op = OP_BSET;
      FN_BADD: dec_op = OP_BADD;
      FN_FWD: begin
        dec_op   = OP_FACC;
        dec_n    = CNT_W'(NUM_NEURONS);
        dec_pend = cmd.last;
      end
      FN_BWD: begin
        dec_op      = OP_BACC;
        dec_n       = CNT_W'(NUM_INPUTS);
        dec_pend    = cmd.last;
        dec_pend_op = OP_BOUT;
        dec_pend_n  = CNT_W'(NUM_INPUTS);
      end
      FN_RDW: dec_op = OP_RDW;
      FN_RDB: dec_op = OP_RDB;
      FN_CLR: begin
        dec_op = OP_CLR;
        dec_n  = CNT_W'(W_DEPTH);
      end
      default: dec_go = 1'b0;
    endcase
  end

  // hold the accepted command
  always_ff @(posedge clk) begin
    if (start && !busy) begin
      itm <= cmd;
    end
  end

  // run, drain, then take the pending emission run or go idle
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_RUN;
      op      <= OP_INIT;
      cnt     <= '0;
      nsteps  <= CNT_W'(W_DEPTH);
      pend    <= 1'b0;
      pend_op <= OP_FOUT;
      pend_n  <= '0;
      dcnt    <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (start && dec_go) begin
            state   <= ST_RUN;
            op      <= dec_op;
            cnt     <= '0;
            nsteps  <= dec_n;
            pend    <= dec_pend;
            pend_op <= dec_pend_op;
            pend_n  <= dec_pend_n;
          end
        end
        ST_RUN: begin
          cnt <= cnt + 1'b1;
          if (cnt == nsteps - 1'b1) begin
            state <= ST_DRAIN;
            dcnt  <= 1'b0;
          end
        end
        ST_DRAIN: begin
          dcnt <= 1'b1;
          if (dcnt) begin
            if (pend) begin
              state  <= ST_RUN;
              op     <= pend_op;
              nsteps <= pend_n;
              cnt    <= '0;
              pend   <= 1'b0;
            end else begin
              state <= ST_IDLE;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign busy     = (state != ST_IDLE);
  assign step.vld = (state == ST_RUN);
  assign step.op  = op;
  assign step.cnt = cnt;

  `DLFB_ASSERT_IMP(a_cnt_in_run, clk, rst, state == ST_RUN, cnt < nsteps)
  `DLFB_ASSERT_NXT(a_fwd_runs, clk, rst, start && !busy && cmd.func == FN_FWD, state == ST_RUN)
  `DLFB_ASSERT_NXT(a_run_end_drains, clk, rst, state == ST_RUN && cnt == nsteps - 1'b1, state == ST_DRAIN)

endmodule

`default_nettype wire

@@ design/dlfb_dp.sv @@
// ----------------------------------------------------------------------------
// dlfb_dp
// Memory datapath: read, multiply, accumulate with saturation, write back.
// ----------------------------------------------------------------------------
`default_nettype none

module dlfb_dp
  import dlfb_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire cmd_t  itm,
  input  wire step_t step,
  output logic       strobe,
  output result_t    result
);

  logic            is_i, is_j, is_c;
  logic [NI_W-1:0] ri;
  logic [NN_W-1:0] rj;
  logic [WA_W-1:0] wa;
  logic            row_ok, col_ok;

  // stage registers
  logic             s1_vld, s2_vld;
  op_e              s1_op, s2_op;
  logic [CNT_W-1:0] s1_cnt, s2_cnt;
  logic [WA_W-1:0]  s1_wa, s2_wa;
  logic [NI_W-1:0]  s1_ri, s2_ri;
  logic [NN_W-1:0]  s1_rj, s2_rj;

  logic signed [15:0] w_rd, b_rd, x_rd;
  logic signed [31:0] g_rd, bg_rd;
  logic signed [39:0] n_rd, ig_rd;

  logic signed [15:0] w_q, b_q;
  logic signed [31:0] g_q, bg_q, prod_w, prod_x;
  logic signed [39:0] n_q, ig_q;

  logic               w_we, b_we, g_we, bg_we, x_we, n_we, ig_we;
  logic signed [15:0] w_wd, b_wd;
  logic signed [31:0] g_wd, bg_wd;
  logic signed [39:0] n_wd, ig_wd;
  logic               clr;

  assign row_ok = (7'(itm.row) < 7'(NUM_INPUTS));
  assign col_ok = (7'(itm.col) < 7'(NUM_NEURONS));

  // read addresses of the issued step
  always_comb begin
    is_i = (step.op == OP_BACC) || (step.op == OP_BOUT);
    is_j = (step.op == OP_FACC) || (step.op == OP_FOUT);
    is_c = (step.op == OP_CLR) || (step.op == OP_INIT);
    ri   = (is_i || is_c) ? step.cnt[NI_W-1:0] : NI_W'(itm.row);
    rj   = (is_j || is_c) ? step.cnt[NN_W-1:0] : NN_W'(itm.col);
    wa   = is_c ? step.cnt[WA_W-1:0] : waddr(ri, rj);
  end

  // advance the step through read and multiply stages
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
      s2_vld <= 1'b0;
    end else begin
      s1_vld <= step.vld;
      s2_vld <= s1_vld;
    end
  end

  always_ff @(posedge clk) begin
    s1_op  <= step.op;
    s1_cnt <= step.cnt;
    s1_wa  <= wa;
    s1_ri  <= ri;
    s1_rj  <= rj;
    s2_op  <= s1_op;
    s2_cnt <= s1_cnt;
    s2_wa  <= s1_wa;
    s2_ri  <= s1_ri;
    s2_rj  <= s1_rj;
    w_q    <= w_rd;
    b_q    <= b_rd;
    g_q    <= g_rd;
    bg_q   <= bg_rd;
    n_q    <= n_rd;
    ig_q   <= ig_rd;
    prod_w <= itm.value * w_rd;
    prod_x <= itm.value * x_rd;
  end

  // write-back stage
  always_comb begin
    clr   = (s2_op == OP_CLR) || (s2_op == OP_INIT);
    w_we  = s2_vld && ((s2_op == OP_WSET) || (s2_op == OP_WADD)) && row_ok && col_ok;
    w_wd  = (s2_op == OP_WSET) ? itm.value : sat16(17'(w_q) + 17'(itm.value));
    b_we  = s2_vld && ((((s2_op == OP_BSET) || (s2_op == OP_BADD)) && col_ok)
                       || (s2_op == OP_INIT));
    b_wd  = (s2_op == OP_INIT) ? 16'sd0 :
            (s2_op == OP_BSET) ? itm.value : sat16(17'(b_q) + 17'(itm.value));
    x_we  = s2_vld && (((s2_op == OP_FACC) && row_ok && (s2_cnt == '0))
                       || (s2_op == OP_INIT));
    n_we  = s2_vld && (((s2_op == OP_FACC) && row_ok) || (s2_op == OP_FOUT)
                       || (s2_op == OP_INIT));
    n_wd  = (s2_op == OP_FACC) ? sat40(41'(n_q) + 41'(prod_w)) : 40'sd0;
    g_we  = s2_vld && (((s2_op == OP_BACC) && col_ok) || clr);
    g_wd  = clr ? 32'sd0 : sat32(41'(g_q) + 41'(prod_x >>> FRAC_BITS));
    bg_we = s2_vld && (((s2_op == OP_BACC) && col_ok && (s2_cnt == '0)) || clr);
    bg_wd = clr ? 32'sd0 : sat32(41'(bg_q) + 41'(itm.value));
    ig_we = s2_vld && (((s2_op == OP_BACC) && col_ok) || (s2_op == OP_BOUT) || clr);
    ig_wd = (s2_op == OP_BACC) ? sat40(41'(ig_q) + 41'(prod_w)) : 40'sd0;
  end

  dlfb_ram #(.DEPTH(W_DEPTH), .WIDTH(16)) u_w_ram (
    .clk(clk), .we(w_we), .waddr(s2_wa), .wdata(w_wd), .raddr(wa), .rdata(w_rd)
  );
  dlfb_ram #(.DEPTH(W_DEPTH), .WIDTH(32)) u_g_ram (
    .clk(clk), .we(g_we), .waddr(s2_wa), .wdata(g_wd), .raddr(wa), .rdata(g_rd)
  );
  dlfb_ram #(.DEPTH(NUM_NEURONS), .WIDTH(16)) u_b_ram (
    .clk(clk), .we(b_we), .waddr(s2_rj), .wdata(b_wd), .raddr(rj), .rdata(b_rd)
  );
  dlfb_ram #(.DEPTH(NUM_NEURONS), .WIDTH(32)) u_bg_ram (
    .clk(clk), .we(bg_we), .waddr(s2_rj), .wdata(bg_wd), .raddr(rj), .rdata(bg_rd)
  );
  dlfb_ram #(.DEPTH(NUM_NEURONS), .WIDTH(40)) u_n_ram (
    .clk(clk), .we(n_we), .waddr(s2_rj), .wdata(n_wd), .raddr(rj), .rdata(n_rd)
  );
  dlfb_ram #(.DEPTH(NUM_INPUTS), .WIDTH(16)) u_x_ram (
    .clk(clk), .we(x_we), .waddr(s2_ri), .wdata(16'(0) | itm.value & {16{~clr}}),
    .raddr(ri), .rdata(x_rd)
  );
  dlfb_ram #(.DEPTH(NUM_INPUTS), .WIDTH(40)) u_ig_ram (
    .clk(clk), .we(ig_we), .waddr(s2_ri), .wdata(ig_wd), .raddr(ri), .rdata(ig_rd)
  );

  // result register, one strobe per transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= s2_vld && ((s2_op == OP_FOUT) || (s2_op == OP_BOUT)
                           || (s2_op == OP_RDW) || (s2_op == OP_RDB));
    end
  end

  always_ff @(posedge clk) begin
    case (s2_op)
      OP_FOUT: begin
        result.kind         <= KIND_OUT;
        result.index        <= 10'(s2_cnt);
        result.result_value <= sat32(41'(n_q >>> FRAC_BITS) + 41'(b_q));
        result.end_of_run   <= (s2_cnt == CNT_W'(NUM_NEURONS - 1));
      end
      OP_BOUT: begin
        result.kind         <= KIND_DX;
        result.index        <= 10'(s2_cnt);
        result.result_value <= sat32(41'(ig_q >>> FRAC_BITS));
        result.end_of_run   <= (s2_cnt == CNT_W'(NUM_INPUTS - 1));
      end
      OP_RDW: begin
        result.kind         <= KIND_DW;
        result.index        <= {itm.row, itm.col};
        result.result_value <= (row_ok && col_ok) ? g_q : 32'sd0;
        result.end_of_run   <= 1'b1;
      end
      default: begin
        result.kind         <= KIND_DB;
        result.index        <= 10'(itm.col);
        result.result_value <= col_ok ? bg_q : 32'sd0;
        result.end_of_run   <= 1'b1;
      end
    endcase
  end

endmodule

`default_nettype wire

@@ design/dense_layer_forward_backward_unit.sv @@
// ----------------------------------------------------------------------------
// dense_layer_forward_backward_unit
// Fully connected layer engine, signed fixed point, forward and backward.
// ----------------------------------------------------------------------------
// channel   ports                  transfer
// command   start, busy, cmd       start high while busy low
// result    strobe, result         strobe high, one cycle, no back-pressure
//
// Each command runs as steps of one memory read-modify-write per cycle, then
// a drain: a weight/bias write or add, or a read, touches one entry; a
// forward element one step per neuron, a backward one per input, each plus
// an output run on the last. Clear gradients sweeps 1024 entries; after
// reset a 1024-step clearing pass runs with busy high. Results leave via the
// read, multiply and result registers; the receiver cannot stall.
`default_nettype none

module dense_layer_forward_backward_unit
  import dlfb_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic start,
  input  wire cmd_t cmd,
  output logic      busy,
  output logic      strobe,
  output result_t   result
);

  cmd_t  itm;
  step_t step;

  dlfb_seq u_seq (
    .clk(clk), .rst(rst), .start(start), .cmd(cmd),
    .busy(busy), .itm(itm), .step(step)
  );

  dlfb_dp u_dp (
    .clk(clk), .rst(rst), .itm(itm), .step(step),
    .strobe(strobe), .result(result)
  );

endmodule

`default_nettype wire
